/* rtl/ps2mpt_pkg.sv */
`default_nettype none
package ps2mpt_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned SIZE_W = 13;
	localparam int unsigned POS_W = 12;
	localparam int unsigned IDX_W = 2;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd2;

	localparam logic [SIZE_W-1:0] WIDTH_RESET = 13'd1024;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd768;

	// byte 0 flag bits
	localparam int unsigned B0_LEFT = 0;
	localparam int unsigned B0_RIGHT = 1;
	localparam int unsigned B0_MIDDLE = 2;
	localparam int unsigned B0_SYNC = 3;
	localparam int unsigned B0_X_OVF = 6;
	localparam int unsigned B0_Y_OVF = 7;

	localparam logic [IDX_W-1:0] IDX_FIRST = 2'd0;
	localparam logic [IDX_W-1:0] IDX_THIRD = 2'd2;
	localparam logic [IDX_W-1:0] IDX_LAST_STD = 2'd2;
	localparam logic [IDX_W-1:0] IDX_LAST_WHEEL = 2'd3;

	typedef struct packed {
		logic               wheel_mode;
		logic [SIZE_W-1:0]  screen_width;
		logic [SIZE_W-1:0]  screen_height;
	} cfg_t;

	typedef struct packed {
		logic              changed;
		logic              moving;
		logic              button_middle;
		logic              button_right;
		logic              button_left;
		logic [POS_W-1:0]  pos_y;
		logic [POS_W-1:0]  pos_x;
	} result_t;

	typedef struct packed {
		logic              take;
		logic              store;
		logic              complete;
		logic [IDX_W-1:0]  next_idx;
	} step_ctl_t;

endpackage
`default_nettype wire

/* rtl/ps2mpt_cfg.sv */
`default_nettype none
module ps2mpt_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [ps2mpt_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [ps2mpt_pkg::SIZE_W-1:0]     wr_data,
	output ps2mpt_pkg::cfg_t                       cfg
);

	ps2mpt_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wheel_mode <= 1'b0;
			cfg_q.screen_width <= ps2mpt_pkg::WIDTH_RESET;
			cfg_q.screen_height <= ps2mpt_pkg::HEIGHT_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				ps2mpt_pkg::REG_WHEEL_MODE: cfg_q.wheel_mode <= wr_data[0];
				ps2mpt_pkg::REG_SCREEN_WIDTH: cfg_q.screen_width <= wr_data;
				ps2mpt_pkg::REG_SCREEN_HEIGHT: cfg_q.screen_height <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* rtl/ps2mpt_step.sv */
`default_nettype none
module ps2mpt_step #(
	parameter int unsigned COORD_BITS = 12
) (
	input  wire logic [ps2mpt_pkg::BYTE_W-1:0]  mouse_byte,
	input  wire logic [ps2mpt_pkg::IDX_W-1:0]   byte_idx,
	input  wire logic [ps2mpt_pkg::BYTE_W-1:0]  pkt0,
	input  wire logic [ps2mpt_pkg::BYTE_W-1:0]  pkt1,
	input  wire logic [ps2mpt_pkg::BYTE_W-1:0]  pkt2,
	input  ps2mpt_pkg::cfg_t                    cfg,
	input  wire logic [COORD_BITS-1:0]          cursor_x,
	input  wire logic [COORD_BITS-1:0]          cursor_y,
	input  wire logic                           last_left,
	input  wire logic                           last_right,
	output ps2mpt_pkg::step_ctl_t               ctl,
	output logic [COORD_BITS-1:0]               next_x,
	output logic [COORD_BITS-1:0]               next_y,
	output ps2mpt_pkg::result_t                 result
);

	localparam int unsigned WW =
		((COORD_BITS > ps2mpt_pkg::SIZE_W) ? COORD_BITS : ps2mpt_pkg::SIZE_W) + 2;
	localparam logic [WW-1:0] CMAX = WW'((1 << COORD_BITS) - 1);

	logic [ps2mpt_pkg::BYTE_W-1:0] b2;
	logic [ps2mpt_pkg::IDX_W-1:0] last_idx;
	logic [WW-1:0] dx, dy, vx, vy, lim_x, lim_y;
	logic left, right;

	function automatic logic [WW-1:0] limit_of(input logic [ps2mpt_pkg::SIZE_W-1:0] size);
		logic [WW-1:0] sm1;
		sm1 = WW'(size) - WW'(1);
		if (size == '0)
			return '0;
		else if (sm1 > CMAX)
			return CMAX;
		else
			return sm1;
	endfunction

	function automatic logic [COORD_BITS-1:0] clamp(input logic [WW-1:0] v,
			input logic [WW-1:0] hi);
		if (v[WW-1])
			return '0;
		else if (v > hi)
			return hi[COORD_BITS-1:0];
		else
			return v[COORD_BITS-1:0];
	endfunction

	always_comb begin
		last_idx = cfg.wheel_mode ? ps2mpt_pkg::IDX_LAST_WHEEL : ps2mpt_pkg::IDX_LAST_STD;
		ctl.take = (byte_idx != ps2mpt_pkg::IDX_FIRST) || mouse_byte[ps2mpt_pkg::B0_SYNC];
		ctl.store = ctl.take && (byte_idx != ps2mpt_pkg::IDX_LAST_WHEEL);
		// a mode change mid-packet may leave the index past the short size
		ctl.complete = ctl.take && (byte_idx >= last_idx);
		// a dropped word leaves the index where it is
		ctl.next_idx = !ctl.take ? byte_idx :
			(ctl.complete ? ps2mpt_pkg::IDX_FIRST : byte_idx + 2'd1);

		b2 = (byte_idx == ps2mpt_pkg::IDX_THIRD) ? mouse_byte : pkt2;
		dx = pkt0[ps2mpt_pkg::B0_X_OVF] ? '0 : {{(WW-8){pkt1[7]}}, pkt1};
		dy = pkt0[ps2mpt_pkg::B0_Y_OVF] ? '0 : {{(WW-8){b2[7]}}, b2};
		vx = {{(WW-COORD_BITS){1'b0}}, cursor_x} + dx;
		vy = {{(WW-COORD_BITS){1'b0}}, cursor_y} - dy;
		lim_x = limit_of(cfg.screen_width);
		lim_y = limit_of(cfg.screen_height);
		next_x = clamp(vx, lim_x);
		next_y = clamp(vy, lim_y);

		left = pkt0[ps2mpt_pkg::B0_LEFT];
		right = pkt0[ps2mpt_pkg::B0_RIGHT];
		result.pos_x = ps2mpt_pkg::POS_W'(next_x);
		result.pos_y = ps2mpt_pkg::POS_W'(next_y);
		result.button_left = left;
		result.button_right = right;
		result.button_middle = pkt0[ps2mpt_pkg::B0_MIDDLE];
		result.moving = (dx != '0) || (dy != '0);
		result.changed = result.moving || (left != last_left) || (right != last_right);
	end

endmodule
`default_nettype wire

/* rtl/ps2_mouse_packet_tracker_core.sv */
// A byte that completes a packet is registered in the input stage, then its result in res_q.
// Throughput: one byte per cycle; the input register and result register decouple the two
// sides, so a stalled result blocks input only once the input stage holds a packet's last byte.
// Reset (arst_n low, asynchronous): packet index, cursor, last buttons and both
// valid flags clear; config returns to 3-byte packets, 1024 x 768.
`default_nettype none
module ps2_mouse_packet_tracker_core #(
	parameter int unsigned COORD_BITS = 12
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,   // [7:0] mouse_byte
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [11:0] pos_x, [23:12] pos_y, [24] button_left, [25] button_right,
	// [26] button_middle, [27] moving, [28] changed, [31:29] zero
	output logic [31:0]       m_axis_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [12:0]  cfg_data
);

	ps2mpt_pkg::cfg_t cfg;
	ps2mpt_pkg::step_ctl_t ctl;
	ps2mpt_pkg::result_t res, res_q;

	logic s1_valid_s1;
	logic [ps2mpt_pkg::BYTE_W-1:0] byte_s1;
	logic [ps2mpt_pkg::IDX_W-1:0] byte_idx_q;
	logic [ps2mpt_pkg::BYTE_W-1:0] pkt0_q, pkt1_q, pkt2_q;
	logic [COORD_BITS-1:0] cursor_x_q, cursor_y_q, next_x, next_y;
	logic last_left_q, last_right_q;
	logic out_valid_q;
	logic s1_go;

	assign cfg_ready = 1'b1;

	ps2mpt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	ps2mpt_step #(
		.COORD_BITS (COORD_BITS)
	) u_step (
		.mouse_byte (byte_s1),
		.byte_idx   (byte_idx_q),
		.pkt0       (pkt0_q),
		.pkt1       (pkt1_q),
		.pkt2       (pkt2_q),
		.cfg        (cfg),
		.cursor_x   (cursor_x_q),
		.cursor_y   (cursor_y_q),
		.last_left  (last_left_q),
		.last_right (last_right_q),
		.ctl        (ctl),
		.next_x     (next_x),
		.next_y     (next_y),
		.result     (res)
	);

	assign s1_go = s1_valid_s1 && (!ctl.complete || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			byte_idx_q <= '0;
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			last_left_q <= 1'b0;
			last_right_q <= 1'b0;
		end else begin
			if (s_axis_tready)
				s1_valid_s1 <= s_axis_tvalid;
			if (s1_go && ctl.complete)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			if (s1_go) begin
				byte_idx_q <= ctl.next_idx;
				if (ctl.complete) begin
					cursor_x_q <= next_x;
					cursor_y_q <= next_y;
					last_left_q <= res.button_left;
					last_right_q <= res.button_right;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			byte_s1 <= s_axis_tdata;
		if (s1_go && ctl.store) begin
			unique case (byte_idx_q)
				2'd0: pkt0_q <= byte_s1;
				2'd1: pkt1_q <= byte_s1;
				2'd2: pkt2_q <= byte_s1;
				default: ;
			endcase
		end
		if (s1_go && ctl.complete)
			res_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {3'b000, res_q};

`ifndef SYNTH
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_s1 |-> s_axis_tready)
		else $error("input stage empty but not ready");

	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_valid_s1))
		else $error("result appeared without a byte in the input stage");

	a_cursor_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(s1_go && ctl.complete) |=> ($stable(cursor_x_q) && $stable(cursor_y_q)))
		else $error("cursor moved without a completed packet");

	a_idx_reset_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && ctl.complete) |=> (byte_idx_q == ps2mpt_pkg::IDX_FIRST))
		else $error("packet index not cleared after a packet");
`endif

endmodule
`default_nettype wire

/* test/ps2_mouse_packet_tracker_core_tb.sv */
`timescale 1ns / 1ps

class cursor_scoreboard;
	localparam int COORD_MAX = (1 << ps2mpt_pkg::POS_W) - 1;

	logic                          wheel_mode = 1'b0;
	logic [ps2mpt_pkg::SIZE_W-1:0] screen_width = ps2mpt_pkg::WIDTH_RESET;
	logic [ps2mpt_pkg::SIZE_W-1:0] screen_height = ps2mpt_pkg::HEIGHT_RESET;
	logic [ps2mpt_pkg::IDX_W-1:0]  byte_idx = ps2mpt_pkg::IDX_FIRST;
	logic [7:0]                    pkt [3] = '{8'h00, 8'h00, 8'h00};
	logic [ps2mpt_pkg::POS_W-1:0]  cur_x = '0;
	logic [ps2mpt_pkg::POS_W-1:0]  cur_y = '0;
	logic                          last_left = 1'b0;
	logic                          last_right = 1'b0;
	ps2mpt_pkg::result_t           pending_reports [$];
	int                            errors = 0;

	function void write_reg(logic [ps2mpt_pkg::CFG_IDX_W-1:0] index,
			logic [ps2mpt_pkg::SIZE_W-1:0] value);
		case (index)
			ps2mpt_pkg::REG_WHEEL_MODE: wheel_mode = value[0];
			ps2mpt_pkg::REG_SCREEN_WIDTH: screen_width = value;
			ps2mpt_pkg::REG_SCREEN_HEIGHT: screen_height = value;
			default: ;
		endcase
	endfunction

	function int pending();
		return pending_reports.size();
	endfunction

	function int coord_limit(logic [ps2mpt_pkg::SIZE_W-1:0] size);
		if (size == 0)
			return 0;
		if (int'(size) - 1 > COORD_MAX)
			return COORD_MAX;
		return int'(size) - 1;
	endfunction

	function int clamp(int v, int hi);
		if (v < 0)
			return 0;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function void track_byte(logic [7:0] b);
		int                  dx, dy;
		int                  pkt_len;
		ps2mpt_pkg::result_t r;
		if (byte_idx == ps2mpt_pkg::IDX_FIRST && !b[ps2mpt_pkg::B0_SYNC])
			return;
		if (byte_idx <= ps2mpt_pkg::IDX_THIRD)
			pkt[byte_idx] = b;
		byte_idx = byte_idx + 1'b1;
		pkt_len = wheel_mode ? 4 : 3;
		if (byte_idx != ps2mpt_pkg::IDX_FIRST && int'(byte_idx) < pkt_len)
			return;
		byte_idx = ps2mpt_pkg::IDX_FIRST;

		dx = int'($signed(pkt[1]));
		dy = int'($signed(pkt[2]));
		if (pkt[0][ps2mpt_pkg::B0_X_OVF])
			dx = 0;
		if (pkt[0][ps2mpt_pkg::B0_Y_OVF])
			dy = 0;
		cur_x = ps2mpt_pkg::POS_W'(clamp(int'(cur_x) + dx, coord_limit(screen_width)));
		cur_y = ps2mpt_pkg::POS_W'(clamp(int'(cur_y) - dy, coord_limit(screen_height)));

		r.pos_x = cur_x;
		r.pos_y = cur_y;
		r.button_left = pkt[0][ps2mpt_pkg::B0_LEFT];
		r.button_right = pkt[0][ps2mpt_pkg::B0_RIGHT];
		r.button_middle = pkt[0][ps2mpt_pkg::B0_MIDDLE];
		r.moving = (dx != 0) || (dy != 0);
		r.changed = r.moving || (r.button_left != last_left) || (r.button_right != last_right);
		last_left = r.button_left;
		last_right = r.button_right;
		pending_reports.push_back(r);
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		$display("ERROR %0t: %s got %0h want %0h", $realtime, what, got, want);
		errors++;
	endtask

	task check_report(logic [31:0] word);
		ps2mpt_pkg::result_t got, want;
		if (pending_reports.size() == 0) begin
			report("word with nothing pending", word, 32'h0);
			return;
		end
		want = pending_reports.pop_front();
		got = word[$bits(ps2mpt_pkg::result_t)-1:0];
		if (got.pos_x !== want.pos_x)
			report("pos_x", got.pos_x, want.pos_x);
		if (got.pos_y !== want.pos_y)
			report("pos_y", got.pos_y, want.pos_y);
		if (got.button_left !== want.button_left)
			report("button_left", got.button_left, want.button_left);
		if (got.button_right !== want.button_right)
			report("button_right", got.button_right, want.button_right);
		if (got.button_middle !== want.button_middle)
			report("button_middle", got.button_middle, want.button_middle);
		if (got.moving !== want.moving)
			report("moving", got.moving, want.moving);
		if (got.changed !== want.changed)
			report("changed", got.changed, want.changed);
		if (word[31:$bits(ps2mpt_pkg::result_t)] !== '0)
			report("pad bits", word[31:$bits(ps2mpt_pkg::result_t)], 32'h0);
	endtask
endclass

module ps2_mouse_packet_tracker_core_tb;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE = 6;
	localparam int HOLD_CYCLES = 400;
	localparam logic [ps2mpt_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef enum int {RX_FULL, RX_MOSTLY, RX_SPARSE, RX_HALF} rx_style_e;

	logic                             clk;
	logic                             arst_n;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	logic [7:0]                       s_axis_tdata;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	logic [31:0]                      m_axis_tdata;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [ps2mpt_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ps2mpt_pkg::SIZE_W-1:0]    cfg_data;

	cursor_scoreboard sb = new;
	int burst_left = 0;
	bit steady = 1'b0;
	int hold_token = 0;

	ps2_mouse_packet_tracker_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.track_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_report(m_axis_tdata);
		end
	end

	// result side: stretches of differing stall density, plus long hold-offs on request
	initial begin
		int        hold_seen, hold_left, stretch_left;
		rx_style_e style;
		hold_seen = 0;
		hold_left = 0;
		stretch_left = 0;
		style = RX_FULL;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (stretch_left == 0) begin
					stretch_left = $urandom_range(16, 160);
					style = rx_style_e'($urandom_range(0, 3));
				end
				stretch_left--;
				case (style)
					RX_FULL: m_axis_tready <= 1'b1;
					RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
					RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= $urandom_range(0, 1);
				endcase
			end
		end
	end

	initial begin
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	task automatic send_byte(logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apply_config(logic [ps2mpt_pkg::SIZE_W-1:0] wheel_val,
			logic [ps2mpt_pkg::SIZE_W-1:0] w, logic [ps2mpt_pkg::SIZE_W-1:0] h, bit spare);
		logic [ps2mpt_pkg::CFG_IDX_W-1:0] idx [4];
		logic [ps2mpt_pkg::SIZE_W-1:0]    val [4];
		int                               n;
		idx = '{ps2mpt_pkg::REG_WHEEL_MODE, ps2mpt_pkg::REG_SCREEN_WIDTH,
			ps2mpt_pkg::REG_SCREEN_HEIGHT, REG_SPARE};
		val = '{wheel_val, w, h, ps2mpt_pkg::SIZE_W'($urandom)};
		n = spare ? 4 : 3;
		for (int i = 0; i < n; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// dir: 0 any, 1 push positive, 2 push negative
	function automatic logic [7:0] pick_delta(int dir);
		int m;
		case ($urandom_range(0, 7))
			0: return 8'h7F;
			1: return 8'h80;
			2: return 8'h00;
			3: return 8'($urandom);
			default: begin
				m = $urandom_range(1, 127);
				if (dir == 1)
					return 8'(m);
				if (dir == 2)
					return 8'(-m);
				return 8'($urandom);
			end
		endcase
	endfunction

	function automatic logic [7:0] pick_head();
		logic [7:0] head;
		head = 8'($urandom);
		head[ps2mpt_pkg::B0_SYNC] = 1'b1;
		head[ps2mpt_pkg::B0_X_OVF] = ($urandom_range(0, 7) == 0);
		head[ps2mpt_pkg::B0_Y_OVF] = ($urandom_range(0, 7) == 0);
		return head;
	endfunction

	task automatic run_phase(int n_bytes);
		int taken, x_dir, y_dir, extra;
		taken = 0;
		x_dir = $urandom_range(0, 2);
		y_dir = $urandom_range(0, 2);
		steady = ($urandom_range(0, 3) == 0);
		while (taken < n_bytes) begin
			case ($urandom_range(0, 15))
				0: send_byte(8'($urandom) & ~8'h08);
				1: begin
					send_byte(8'($urandom));
					taken++;
				end
				default: begin
					send_byte(pick_head());
					send_byte(pick_delta(x_dir));
					send_byte(pick_delta(y_dir));
					taken += 3;
					if (sb.wheel_mode) begin
						send_byte(8'($urandom));
						taken++;
					end
				end
			endcase
		end
		// leave a packet open across the next register write now and then
		if ($urandom_range(0, 1)) begin
			send_byte(pick_head());
			extra = $urandom_range(0, 2);
			repeat (extra) send_byte(8'($urandom));
		end
		steady = 1'b0;
	endtask

	initial begin
		logic [7:0] opening [20];
		logic [ps2mpt_pkg::SIZE_W-1:0] w, h;
		opening = '{
			8'h00, 8'hF7,
			8'h08, 8'h7F, 8'h80,
			8'h09, 8'h80, 8'h7F,
			8'hCB, 8'hFF, 8'hFF,
			8'h0C, 8'h00, 8'h00,
			8'h0C, 8'h00, 8'h00,
			8'hFF, 8'h01, 8'h01
		};
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= 8'h00;
		cfg_valid <= 1'b0;
		cfg_index <= ps2mpt_pkg::REG_WHEEL_MODE;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i])
			send_byte(opening[i]);
		drain();

		apply_config(13'd1, 13'd4096, 13'd4096, 1'b1);
		run_phase(200);
		drain();
		apply_config(13'd0, 13'd1, 13'd1, 1'b0);
		run_phase(80);
		drain();
		apply_config(13'h1FFF, 13'd0, 13'd0, 1'b0);
		run_phase(80);
		drain();
		apply_config(13'h1FFE, 13'h1FFF, 13'h1FFF, 1'b1);
		hold_token++;
		run_phase(200);
		drain();

		for (int p = 0; p < 8; p++) begin
			case ($urandom_range(0, 3))
				0: begin
					w = $urandom_range(1, 64);
					h = $urandom_range(1, 64);
				end
				1: begin
					w = $urandom_range(4097, 8191);
					h = $urandom_range(1, 4096);
				end
				default: begin
					w = $urandom_range(1, 4096);
					h = $urandom_range(1, 4096);
				end
			endcase
			apply_config(ps2mpt_pkg::SIZE_W'($urandom), w, h, $urandom_range(0, 1));
			if (p == 5)
				hold_token++;
			run_phase(160);
			drain();
		end

		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
